// File: hw/rtl/qcsm_pkg.sv
// ----------------------------------------------------------------------------
// qcsm_pkg: shared types and constants for the quad crop size measure
// Field widths, status codes and the coordinate, difference and length types.
// ----------------------------------------------------------------------------
package qcsm_pkg;
	localparam int CoordBits = 20;
	localparam int FracBits  = 4;
	localparam int LenBits   = 17;
	localparam int DiffBits  = CoordBits + 1;
	localparam int SqBits    = 2 * DiffBits + 1;
	localparam int RootBits  = (SqBits + 1) / 2;
	localparam int LimBits   = LenBits + FracBits;

	localparam logic [1:0] StatusOk      = 2'd0;
	localparam logic [1:0] StatusInvalid = 2'd1;
	localparam logic [1:0] StatusEmpty   = 2'd2;

	localparam logic [LenBits-1:0] LenMax = '1;
	localparam logic [15:0] RatioReset   = 16'd384;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0] diff_t;
	typedef logic [LenBits-1:0] len_t;
endpackage

// File: hw/rtl/qcsm_cross_lane.sv
// ----------------------------------------------------------------------------
// qcsm_cross_lane: one corner cross product sign test
// Registers both products, then registers their comparison as the result.
// ----------------------------------------------------------------------------
module qcsm_cross_lane (
	input  logic                  clk,
	input  logic                  en,
	input  qcsm_pkg::coord_t      xi,
	input  qcsm_pkg::coord_t      yi,
	input  qcsm_pkg::coord_t      xn,
	input  qcsm_pkg::coord_t      yn,
	input  qcsm_pkg::coord_t      xf,
	input  qcsm_pkg::coord_t      yf,
	output logic                  pos
);
	localparam int PBits = 2 * qcsm_pkg::DiffBits;
	qcsm_pkg::diff_t ax, by, ay, bx;
	logic signed [PBits-1:0] p_s1, q_s1;

	assign ax = qcsm_pkg::diff_t'(xn) - qcsm_pkg::diff_t'(xi);
	assign by = qcsm_pkg::diff_t'(yf) - qcsm_pkg::diff_t'(yn);
	assign ay = qcsm_pkg::diff_t'(yn) - qcsm_pkg::diff_t'(yi);
	assign bx = qcsm_pkg::diff_t'(xf) - qcsm_pkg::diff_t'(xn);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= ax * by;
			q_s1 <= ay * bx;
			pos  <= p_s1 > q_s1;
		end
	end
endmodule

// File: hw/rtl/qcsm_edge_lane.sv
// ----------------------------------------------------------------------------
// qcsm_edge_lane: floored edge length of one edge
// Squares the deltas, then a pipelined restoring square root, one bit a stage.
// ----------------------------------------------------------------------------
module qcsm_edge_lane (
	input  logic                  clk,
	input  logic                  en,
	input  qcsm_pkg::coord_t      ax,
	input  qcsm_pkg::coord_t      ay,
	input  qcsm_pkg::coord_t      bx,
	input  qcsm_pkg::coord_t      by,
	output qcsm_pkg::len_t        len
);
	localparam int DB = qcsm_pkg::DiffBits;
	localparam int SB = qcsm_pkg::SqBits;
	localparam int RB = qcsm_pkg::RootBits;
	localparam int SS = SB - 2 * qcsm_pkg::FracBits;
	localparam int NS = (SS + 1) / 2;
	localparam int RW = RB + 2;

	qcsm_pkg::diff_t dx, dy;
	logic [DB-1:0] mx, my;
	logic          sat_in;
	logic [2*DB-1:0] sx_s1, sy_s1;
	logic            sat_s1;
	logic [SB-1:0]   s_s2;
	logic            sat_s2;
	logic [2*NS-1:0] rem_q [0:NS];
	logic [RW-1:0]   acc_q [0:NS];
	logic [NS-1:0]   root_q [0:NS];
	logic [NS:0]     sat_q;

	assign dx = qcsm_pkg::diff_t'(ax) - qcsm_pkg::diff_t'(bx);
	assign dy = qcsm_pkg::diff_t'(ay) - qcsm_pkg::diff_t'(by);
	assign mx = dx[DB-1] ? DB'(-dx) : DB'(dx);
	assign my = dy[DB-1] ? DB'(-dy) : DB'(dy);
	assign sat_in = (64'(mx) >= (64'd1 << qcsm_pkg::LimBits))
		|| (64'(my) >= (64'd1 << qcsm_pkg::LimBits));

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1  <= mx * mx;
			sy_s1  <= my * my;
			sat_s1 <= sat_in;
			s_s2   <= SB'(sx_s1) + SB'(sy_s1);
			sat_s2 <= sat_s1;
		end
	end

	// digit-by-digit root, two radicand bits per stage
	always_comb begin
		rem_q[0]  = (2*NS)'(s_s2 >> (2 * qcsm_pkg::FracBits));
		acc_q[0]  = '0;
		root_q[0] = '0;
		sat_q[0]  = sat_s2;
	end

	for (genvar k = 0; k < NS; k++) begin : g_st
		logic [RW-1:0] a_n, t_n;
		logic [NS-1:0] r_n;
		always_comb begin
			a_n = RW'({acc_q[k], rem_q[k][2*NS-1 -: 2]});
			t_n = RW'({root_q[k], 2'b01});
			r_n = {root_q[k][NS-2:0], 1'b0};
			if (a_n >= t_n) begin
				a_n = a_n - t_n;
				r_n[0] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1]  <= {rem_q[k][2*NS-3:0], 2'b00};
				acc_q[k+1]  <= a_n;
				root_q[k+1] <= r_n;
				sat_q[k+1]  <= sat_q[k];
			end
		end
	end

	assign len = (sat_q[NS] || (root_q[NS] > NS'(qcsm_pkg::LenMax)))
		? qcsm_pkg::LenMax : qcsm_pkg::LenBits'(root_q[NS]);
endmodule

// File: hw/rtl/qcsm_merge.sv
// ----------------------------------------------------------------------------
// qcsm_merge: combines lane results into status, size and rotate flag
// Picks maxima, applies validity and builds the rotation compare; registered.
// ----------------------------------------------------------------------------
module qcsm_merge (
	input  logic                  clk,
	input  logic                  en,
	input  logic [3:0]            pos,
	input  qcsm_pkg::len_t        e01,
	input  qcsm_pkg::len_t        e23,
	input  qcsm_pkg::len_t        e03,
	input  qcsm_pkg::len_t        e12,
	input  logic [15:0]           ratio,
	output logic [1:0]            status,
	output qcsm_pkg::len_t        w_out,
	output qcsm_pkg::len_t        h_out,
	output logic                  rot
);
	qcsm_pkg::len_t w, h;
	logic [1:0] st_s1;
	qcsm_pkg::len_t w_s1, h_s1;
	logic [qcsm_pkg::LenBits+15:0] hs_s1, rw_s1;

	assign w = (e23 > e01) ? e23 : e01;
	assign h = (e12 > e03) ? e12 : e03;

	always_ff @(posedge clk) begin
		if (en) begin
			if (pos != 4'hf) st_s1 <= qcsm_pkg::StatusInvalid;
			else if (w == '0 || h == '0) st_s1 <= qcsm_pkg::StatusEmpty;
			else st_s1 <= qcsm_pkg::StatusOk;
			w_s1  <= w;
			h_s1  <= h;
			hs_s1 <= {8'd0, h, 8'd0};
			rw_s1 <= ratio * w;
			status <= st_s1;
			w_out  <= (st_s1 == qcsm_pkg::StatusOk) ? w_s1 : '0;
			h_out  <= (st_s1 == qcsm_pkg::StatusOk) ? h_s1 : '0;
			rot    <= (st_s1 == qcsm_pkg::StatusOk) && (hs_s1 >= rw_s1);
		end
	end
endmodule

// File: hw/rtl/quad_crop_size_measure.sv
// ----------------------------------------------------------------------------
// quad_crop_size_measure: crop width, height and rotation of one quad
// Cross-product lanes, one per corner, and edge-length lanes, one per edge, feed a merge block.
// ----------------------------------------------------------------------------
// Usage: s_axis beats carry the eight corners (20 bit signed each, x then y,
// corner 0 first). m_axis beats carry status, crop_width, crop_height and
// rotate_ccw. cfg writes tall_ratio_q8 (reset 384) and is always ready; write
// it only while the block is idle.
// Throughput: one quad per cycle unless m_axis stalls. The pipe holds 22
// register stages (squares, sum, 18 root stages, two merge stages).
// The pipeline is a lockstep shift with one valid bit per stage; it advances
// whenever the output register is empty or being drained, so a stalled
// receiver freezes the whole pipe and s_axis_tready falls with it.
// Reset clears the valid bits and sets the ratio to 384; no clearing pass.
// ----------------------------------------------------------------------------
module quad_crop_size_measure (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [159:0] s_axis_tdata,  // c0x,c0y,c1x,c1y,c2x,c2y,c3x,c3y
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,  // status,crop_width,crop_height,rotate_ccw,pad
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	localparam int Depth = 2 + (qcsm_pkg::SqBits - 2 * qcsm_pkg::FracBits + 1) / 2 + 2;
	localparam int CB = qcsm_pkg::CoordBits;

	logic [15:0] ratio_q;
	logic [Depth-1:0] vld_q;
	logic en;
	qcsm_pkg::coord_t cx [0:3];
	qcsm_pkg::coord_t cy [0:3];
	logic [3:0] pos_c;
	logic [3:0] pos_d [0:Depth-4];
	qcsm_pkg::len_t e01, e23, e03, e12;
	logic [1:0] status;
	qcsm_pkg::len_t wd, ht;
	logic rot;

	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[Depth-1];
	assign cfg_ready = 1'b1;

	for (genvar i = 0; i < 4; i++) begin : g_c
		assign cx[i] = s_axis_tdata[2*i*CB +: CB];
		assign cy[i] = s_axis_tdata[(2*i+1)*CB +: CB];
		qcsm_cross_lane u_cross (
			.clk(clk), .en(en),
			.xi(cx[i]), .yi(cy[i]),
			.xn(cx[(i+1)%4]), .yn(cy[(i+1)%4]),
			.xf(cx[(i+2)%4]), .yf(cy[(i+2)%4]),
			.pos(pos_c[i])
		);
	end

	// align cross results with the root pipeline
	assign pos_d[0] = pos_c;
	for (genvar k = 1; k <= Depth-4; k++) begin : g_d
		always_ff @(posedge clk) begin
			if (en) pos_d[k] <= pos_d[k-1];
		end
	end

	qcsm_edge_lane u_e01 (.clk(clk), .en(en), .ax(cx[0]), .ay(cy[0]),
		.bx(cx[1]), .by(cy[1]), .len(e01));
	qcsm_edge_lane u_e23 (.clk(clk), .en(en), .ax(cx[2]), .ay(cy[2]),
		.bx(cx[3]), .by(cy[3]), .len(e23));
	qcsm_edge_lane u_e03 (.clk(clk), .en(en), .ax(cx[0]), .ay(cy[0]),
		.bx(cx[3]), .by(cy[3]), .len(e03));
	qcsm_edge_lane u_e12 (.clk(clk), .en(en), .ax(cx[1]), .ay(cy[1]),
		.bx(cx[2]), .by(cy[2]), .len(e12));

	qcsm_merge u_merge (
		.clk(clk), .en(en), .pos(pos_d[Depth-4]),
		.e01(e01), .e23(e23), .e03(e03), .e12(e12),
		.ratio(ratio_q), .status(status), .w_out(wd), .h_out(ht), .rot(rot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			ratio_q <= qcsm_pkg::RatioReset;
		end else begin
			if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
			if (cfg_valid) ratio_q <= cfg_data;
		end
	end

	assign m_axis_tdata = {3'd0, rot, ht, wd, status};
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: quad crop size measure testbench
// Streams quads (directed corner cases, then random convex and noise quads),
// predicts status, size and rotation per quad, and checks every output beat
// in order under several idle/stall mixes and ratio settings.
// ----------------------------------------------------------------------------
module tb_top;
	typedef struct packed {
		logic           rot;
		qcsm_pkg::len_t h;
		qcsm_pkg::len_t w;
		logic [1:0]     st;
	} crop_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;  // c0x,c0y,c1x,c1y,c2x,c2y,c3x,c3y
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;  // status,crop_width,crop_height,rotate_ccw,pad
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	quad_crop_size_measure DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	crop_t       crop_q[$];
	logic [15:0] ratio;
	int          errors;
	int          n_quads;
	int          n_ok, n_inv, n_empty, n_rot;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_cycles;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// exact edge length floor, saturated
	function automatic qcsm_pkg::len_t edge_len(longint ax, longint ay, longint bx,
		longint by);
		longint dx, dy, s, r, t;
		dx = ax - bx; if (dx < 0) dx = -dx;
		dy = ay - by; if (dy < 0) dy = -dy;
		if (dx >= (64'sd1 << qcsm_pkg::LimBits) || dy >= (64'sd1 << qcsm_pkg::LimBits))
			return qcsm_pkg::LenMax;
		s = (dx * dx + dy * dy) >>> (2 * qcsm_pkg::FracBits);
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'sd1 << b);
			if (t * t <= s) r = t;
		end
		return (r > longint'(qcsm_pkg::LenMax)) ? qcsm_pkg::LenMax : qcsm_pkg::len_t'(r);
	endfunction

	function automatic crop_t measure_crop(logic [159:0] d);
		longint x[4], y[4], l0, l1, cp;
		crop_t  c;
		int     n, f;
		for (int i = 0; i < 4; i++) begin
			x[i] = longint'(qcsm_pkg::coord_t'(d[40*i +: 20]));
			y[i] = longint'(qcsm_pkg::coord_t'(d[40*i+20 +: 20]));
		end
		c = '0;
		for (int i = 0; i < 4; i++) begin
			n = (i + 1) & 3; f = (i + 2) & 3;
			cp = (x[n] - x[i]) * (y[f] - y[n]) - (y[n] - y[i]) * (x[f] - x[n]);
			if (cp <= 0) begin
				c.st = qcsm_pkg::StatusInvalid;
				return c;
			end
		end
		l0 = edge_len(x[0], y[0], x[1], y[1]);
		l1 = edge_len(x[2], y[2], x[3], y[3]);
		c.w = qcsm_pkg::len_t'((l1 > l0) ? l1 : l0);
		l0 = edge_len(x[0], y[0], x[3], y[3]);
		l1 = edge_len(x[1], y[1], x[2], y[2]);
		c.h = qcsm_pkg::len_t'((l1 > l0) ? l1 : l0);
		if (c.w == 0 || c.h == 0) begin
			c = '0;
			c.st = qcsm_pkg::StatusEmpty;
			return c;
		end
		c.st  = qcsm_pkg::StatusOk;
		c.rot = (64'd256 * c.h >= 64'(ratio) * c.w);
		return c;
	endfunction

	task automatic send_quad(logic [159:0] d);
		while (($urandom_range(99) < send_idle_pct)) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		crop_q = {crop_q, measure_crop(d)};
		n_quads++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (crop_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
	endtask

	task automatic write_ratio(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ratio = v;
	endtask

	function automatic logic [159:0] pack_quad(int px[4], int py[4]);
		logic [159:0] d;
		for (int i = 0; i < 4; i++) begin
			d[40*i +: 20]    = px[i][19:0];
			d[40*i+20 +: 20] = py[i][19:0];
		end
		return d;
	endfunction

	// clockwise in screen coordinates: x right, y down
	function automatic logic [159:0] rect_quad(int x0, int y0, int w, int h);
		int px[4], py[4];
		px = '{x0, x0 + w, x0 + w, x0};
		py = '{y0, y0, y0 + h, y0 + h};
		return pack_quad(px, py);
	endfunction

	function automatic logic [159:0] random_convex();
		int cx, cy, r, px[4], py[4];
		r  = ($urandom_range(9) == 0) ? $urandom_range(250000) : $urandom_range(2000);
		cx = int'($urandom_range(2 * (524287 - r))) - (524287 - r);
		cy = int'($urandom_range(2 * (524287 - r))) - (524287 - r);
		// one corner per quadrant, jittered; mostly convex and clockwise, but concave or degenerate quads can occur
		px[0] = cx - int'($urandom_range(r)); py[0] = cy - int'($urandom_range(r));
		px[1] = cx + int'($urandom_range(r)); py[1] = cy - int'($urandom_range(r));
		px[2] = cx + int'($urandom_range(r)); py[2] = cy + int'($urandom_range(r));
		px[3] = cx - int'($urandom_range(r)); py[3] = cy + int'($urandom_range(r));
		return pack_quad(px, py);
	endfunction

	function automatic logic [159:0] random_quad();
		int k;
		logic [159:0] d;
		k = $urandom_range(9);
		if (k < 6) return random_convex();
		if (k < 8) begin
			// reversed winding
			d = random_convex();
			return {d[39:0], d[79:40], d[119:80], d[159:120]};
		end
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// output side: random stall plus an optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles   <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		crop_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = crop_t'(m_axis_tdata[36:0]);
			if (crop_q.size() == 0) begin
				$error("beat with no quad outstanding: %h", m_axis_tdata);
				errors++;
			end else begin
				want = crop_q.pop_front();
				if (got.st !== want.st) begin
					$error("status exp %0d got %0d", want.st, got.st); errors++;
				end
				if (got.w !== want.w) begin
					$error("crop_width exp %0d got %0d", want.w, got.w); errors++;
				end
				if (got.h !== want.h) begin
					$error("crop_height exp %0d got %0d", want.h, got.h); errors++;
				end
				if (got.rot !== want.rot) begin
					$error("rotate_ccw exp %0d got %0d", want.rot, got.rot); errors++;
				end
				case (want.st)
					qcsm_pkg::StatusOk:      n_ok++;
					qcsm_pkg::StatusInvalid: n_inv++;
					default:                 n_empty++;
				endcase
				if (want.rot) n_rot++;
			end
		end
	end

	task automatic test_directed();
		int px[4], py[4];
		send_quad(rect_quad(0, 0, 160, 320));
		send_quad(rect_quad(0, 0, 320, 160));
		send_quad(rect_quad(0, 0, 15, 160));        // empty width
		send_quad(rect_quad(0, 0, 160, 15));        // empty height
		send_quad(rect_quad(0, 0, 16, 16));
		send_quad(rect_quad(-524288, -524288, 1048575, 1048575)); // full coordinate range
		send_quad(rect_quad(-524288, 0, 1048575, 32));
		send_quad(rect_quad(100, 100, 0, 50));      // degenerate, zero cross
		send_quad('0);
		send_quad({160{1'b1}});
		send_quad({8{20'h80000}});
		send_quad({8{20'h7FFFF}});
		px = '{0, 0, 320, 320}; py = '{0, 320, 320, 0}; // counterclockwise
		send_quad(pack_quad(px, py));
		px = '{0, 320, 100, 320}; py = '{0, 0, 100, 320}; // concave
		send_quad(pack_quad(px, py));
		px = '{0, 320, 160, 320}; py = '{0, 0, 160, 320}; // collinear corner
		send_quad(pack_quad(px, py));
		px = '{-524288, 524287, 524287, -524288};
		py = '{-524288, -524288, 524287, 524287};
		send_quad(pack_quad(px, py));
		send_quad(rect_quad(0, 0, 256, 384));       // ratio boundary at 384
		send_quad(rect_quad(0, 0, 256, 383));
		px = '{0, 500, 520, -10}; py = '{0, 30, 700, 650}; // skewed
		send_quad(pack_quad(px, py));
	endtask

	task automatic test_random(int count);
		repeat (count) send_quad(random_quad());
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0; recv_stall_pct = 0;
		hold_cycles = 300;
		repeat (60) send_quad(random_quad());
		drain();   // sender pause until all results are back
		repeat (20) send_quad(random_quad());
	endtask

	task automatic test_ratio_sweep();
		write_ratio(16'd0);
		test_random(100);
		write_ratio(16'd1);
		test_random(100);
		write_ratio(16'hFFFF);
		test_random(100);
		write_ratio(16'd256);
		test_directed();
	endtask

	initial begin
		errors = 0; n_quads = 0; n_ok = 0; n_inv = 0; n_empty = 0; n_rot = 0;
		send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
		ratio = qcsm_pkg::RatioReset;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0;
		cfg_valid = 1'b0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle_pct = 0;  recv_stall_pct = 0;  test_random(400);
		send_idle_pct = 74; recv_stall_pct = 0;  test_random(300);
		send_idle_pct = 0;  recv_stall_pct = 74; test_random(300);
		send_idle_pct = 38; recv_stall_pct = 38; test_random(300);
		test_backpressure();
		send_idle_pct = 38; recv_stall_pct = 38;
		test_ratio_sweep();
		write_ratio(qcsm_pkg::RatioReset);
		send_idle_pct = 0; recv_stall_pct = 0; test_random(200);
		drain();

		$display("%0d quads: %0d ok (%0d rotated), %0d invalid, %0d empty",
			n_quads, n_ok, n_rot, n_inv, n_empty);
		$display("ratio settings 0, 1, 256, 384, 65535; idle/stall mixes and a long hold-off");
		if (errors == 0 && crop_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			if (crop_q.size() != 0) $error("%0d results never arrived", crop_q.size());
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

// File: files.f
hw/rtl/qcsm_pkg.sv
hw/rtl/qcsm_cross_lane.sv
hw/rtl/qcsm_edge_lane.sv
hw/rtl/qcsm_merge.sv
hw/rtl/quad_crop_size_measure.sv
tb/sv/tb_top.sv
